// File: hdl/swrr_pkg.sv
// Shared types, constants and helpers for the smooth WRR client assigner.
`default_nettype none
package swrr_pkg;

  localparam int NUM_SRV          = 5;
  localparam int CLIENT_COUNT_DEF = 256;

  localparam logic [7:0] CAP_RESET [NUM_SRV] = '{8'd40, 8'd20, 8'd30, 8'd70, 8'd40};

  localparam logic [3:0] UNBOUND = 4'd15;

  localparam logic [2:0] ST_FWD    = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_LINKDN = 3'd2;
  localparam logic [2:0] ST_REL    = 3'd3;
  localparam logic [2:0] ST_UNB    = 3'd4;

  localparam logic signed [25:0] RW_MAX = 26'sd8388607;
  localparam logic signed [25:0] RW_MIN = -26'sd8388608;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > RW_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < RW_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/swrr_ctrl.sv
// Sequencer: clearing pass, idle, execute.
`default_nettype none
module swrr_ctrl
  import swrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   busy_r;

  assign busy = busy_r;

  always_comb begin
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.accept   = (state_r == S_IDLE) && start;
    cmd.exec     = (state_r == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_CLEAR;
          busy_r  <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/swrr_dp.sv
// Datapath: binding memory, server loads, running weights, pick and result word.
`default_nettype none
module swrr_dp
  import swrr_pkg::*;
#(
  parameter int CLIENT_COUNT = CLIENT_COUNT_DEF
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_client_id,
  input  wire logic [4:0]  in_link_up_mask,
  input  wire logic [7:0]  in_flag_bits,
  input  wire logic [63:0] in_temp_identity,
  input  wire logic [63:0] in_short_identity,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [2:0]       out_server_index,
  output logic [7:0]       out_client_out,
  output logic [7:0]       out_flag_bits_out,
  output logic [63:0]      out_temp_identity_out,
  output logic [63:0]      out_short_identity_out
);

  localparam int AW = $clog2(CLIENT_COUNT);

  logic [3:0]  mem [CLIENT_COUNT];
  logic [3:0]  rd_r;
  logic [AW-1:0] clr_cnt_r;

  logic [7:0]         cap_r  [NUM_SRV];
  logic [8:0]         load_r [NUM_SRV];
  logic signed [23:0] rw_r     [NUM_SRV];
  logic signed [23:0] rw_inc_r [NUM_SRV];

  logic        req_r;
  logic [7:0]  cid_r;
  logic [4:0]  links_r;
  logic [7:0]  flags_r;
  logic [63:0] temp_r;
  logic [63:0] short_r;
  logic        in_range_r;
  logic [AW-1:0] addr_r;

  logic [AW+7:0] cid_ext;
  logic [AW-1:0] cid_addr;
  logic          cid_in_range;
  logic [10:0]   total;

  logic          bound;
  logic [2:0]    bsrv;
  logic          found;
  logic [2:0]    best;
  logic signed [23:0] lead_w;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [3:0]    mem_wdata;
  logic          bind_we;
  logic [3:0]    bind_code;
  logic          rw_commit;
  logic          inc_en;
  logic          dec_en;
  logic [2:0]    ld_sel;
  logic [2:0]    st;
  logic [2:0]    srv;
  logic          fwd;

  assign cid_ext      = (AW+8)'(in_client_id);
  assign cid_addr     = cid_ext[AW-1:0];
  assign cid_in_range = (32'(in_client_id) < 32'(CLIENT_COUNT));
  assign sts.clr_last = (clr_cnt_r == AW'(CLIENT_COUNT - 1));

  always_comb begin
    total = 11'(cap_r[0]) + 11'(cap_r[1]) + 11'(cap_r[2]) + 11'(cap_r[3]) + 11'(cap_r[4]);
  end

  // tie goes to the lowest index
  always_comb begin
    found  = 1'b0;
    best   = 3'd0;
    lead_w = 24'sd0;
    for (int i = 0; i < NUM_SRV; i++) begin
      if ((load_r[i] < {1'b0, cap_r[i]}) && (!found || (rw_inc_r[i] > lead_w))) begin
        found  = 1'b1;
        best   = 3'(i);
        lead_w = rw_inc_r[i];
      end
    end
  end

  always_comb begin
    bound     = (rd_r < 4'(NUM_SRV));
    bsrv      = rd_r[2:0];
    bind_we   = 1'b0;
    bind_code = UNBOUND;
    rw_commit = 1'b0;
    inc_en    = 1'b0;
    dec_en    = 1'b0;
    ld_sel    = 3'd0;
    st        = ST_FULL;
    srv       = 3'd0;
    fwd       = 1'b0;
    if (!in_range_r) begin
      st = req_r ? ST_UNB : ST_FULL;
    end else if (req_r) begin
      bind_we = 1'b1;
      if (bound) begin
        dec_en = 1'b1;
        ld_sel = bsrv;
        st     = ST_REL;
        srv    = bsrv;
      end else begin
        st = ST_UNB;
      end
    end else if (bound) begin
      bind_we = 1'b1;
      srv     = bsrv;
      if (links_r[bsrv]) begin
        bind_code = rd_r;
        st        = ST_FWD;
        fwd       = 1'b1;
      end else begin
        dec_en = 1'b1;
        ld_sel = bsrv;
        st     = ST_LINKDN;
      end
    end else begin
      rw_commit = 1'b1;
      if (found) begin
        bind_we = 1'b1;
        srv     = best;
        if (links_r[best]) begin
          inc_en    = 1'b1;
          ld_sel    = best;
          bind_code = {1'b0, best};
          st        = ST_FWD;
          fwd       = 1'b1;
        end else begin
          st = ST_LINKDN;
        end
      end
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.exec && bind_we);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign mem_wdata = cmd.clr_step ? UNBOUND : bind_code;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[cid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r      <= in_req_type;
      cid_r      <= in_client_id;
      links_r    <= in_link_up_mask;
      flags_r    <= in_flag_bits;
      temp_r     <= in_temp_identity;
      short_r    <= in_short_identity;
      in_range_r <= cid_in_range;
      addr_r     <= cid_addr;
      for (int i = 0; i < NUM_SRV; i++) begin
        rw_inc_r[i] <= sat24($signed({{2{rw_r[i][23]}}, rw_r[i]}) +
                             $signed({18'd0, cap_r[i]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SRV; i++) begin
        cap_r[i]  <= CAP_RESET[i];
        load_r[i] <= 9'd0;
        rw_r[i]   <= 24'sd0;
      end
    end else begin
      if (cfg_we && (cfg_index < 3'(NUM_SRV))) begin
        cap_r[cfg_index] <= cfg_data;
      end
      if (cmd.exec) begin
        for (int i = 0; i < NUM_SRV; i++) begin
          if (inc_en && (ld_sel == 3'(i))) begin
            load_r[i] <= load_r[i] + 9'd1;
          end else if (dec_en && (ld_sel == 3'(i)) && (load_r[i] != 9'd0)) begin
            load_r[i] <= load_r[i] - 9'd1;
          end
          if (rw_commit) begin
            if (found && (best == 3'(i))) begin
              rw_r[i] <= sat24($signed({{2{rw_inc_r[i][23]}}, rw_inc_r[i]}) -
                               $signed({15'd0, total}));
            end else begin
              rw_r[i] <= rw_inc_r[i];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status             <= st;
      out_server_index       <= srv;
      out_client_out         <= cid_r;
      out_flag_bits_out      <= fwd ? flags_r : 8'd0;
      out_temp_identity_out  <= fwd ? temp_r : 64'd0;
      out_short_identity_out <= fwd ? short_r : 64'd0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/capacity_limited_smooth_wrr_assigner_core.sv
// Top level: capacity-limited smooth weighted round-robin client assigner.
// Start taken in idle enters execute, which registers the result word and out_valid.
// The next word is taken back in idle, after the binding read and its write-back.
// Reset: synchronous; capacities return to defaults, loads and weights clear, and a
// clearing pass marks all CLIENT_COUNT bindings unbound while busy is high.
// The receiver cannot stall; cfg writes are taken at any cycle.
`default_nettype none
module capacity_limited_smooth_wrr_assigner_core
  import swrr_pkg::*;
#(
  parameter int CLIENT_COUNT = CLIENT_COUNT_DEF
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_client_id,
  input  wire logic [4:0]  in_link_up_mask,
  input  wire logic [7:0]  in_flag_bits,
  input  wire logic [63:0] in_temp_identity,
  input  wire logic [63:0] in_short_identity,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [2:0]       out_server_index,
  output logic [7:0]       out_client_out,
  output logic [7:0]       out_flag_bits_out,
  output logic [63:0]      out_temp_identity_out,
  output logic [63:0]      out_short_identity_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  swrr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  swrr_dp #(
    .CLIENT_COUNT (CLIENT_COUNT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_req_type            (in_req_type),
    .in_client_id           (in_client_id),
    .in_link_up_mask        (in_link_up_mask),
    .in_flag_bits           (in_flag_bits),
    .in_temp_identity       (in_temp_identity),
    .in_short_identity      (in_short_identity),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_server_index       (out_server_index),
    .out_client_out         (out_client_out),
    .out_flag_bits_out      (out_flag_bits_out),
    .out_temp_identity_out  (out_temp_identity_out),
    .out_short_identity_out (out_short_identity_out)
  );

endmodule
`default_nettype wire

// File: hdl/swrr_checker.sv
// Port-level checker for the assigner core, bound to the top level.
`default_nettype none
module swrr_checker
  import swrr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [2:0]  out_server_index,
  input wire logic [7:0]  out_flag_bits_out,
  input wire logic [63:0] out_temp_identity_out,
  input wire logic [63:0] out_short_identity_out
);

  a_word_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word did not produce a result two edges later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a preceding accepted word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after accepting a word");

  a_zero_unless_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_FWD)) |->
      ((out_flag_bits_out == 8'd0) && (out_temp_identity_out == 64'd0) &&
       (out_short_identity_out == 64'd0)))
    else $error("payload forwarded on a non-forward status");

  a_no_server_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == ST_FULL) || (out_status == ST_UNB))) |->
      (out_server_index == 3'd0))
    else $error("server index set on a result without a server");

endmodule

bind capacity_limited_smooth_wrr_assigner_core swrr_checker u_chk (.*);
`default_nettype wire
